// ----- rtl/core/brt_pkg.sv -----
// Package for the bin run table engine: sizes, request and status codes.
// No dependencies.
package brt_pkg;
    localparam int BIN_COUNT    = 4096;
    localparam int BIN_CAPACITY = 16;
    localparam int MAX_RUN      = 16;
    localparam int ELEMENT_BITS = 60;
    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int SLOT_W = $clog2(BIN_CAPACITY);
    localparam int CNT_W  = $clog2(BIN_CAPACITY + 1);
    localparam int ADDR_W = BIN_W + SLOT_W;
    localparam int RUN_W  = $clog2(MAX_RUN);
    localparam int RLEN_W = $clog2(MAX_RUN + 2);
    localparam int TOT_W  = $clog2(BIN_COUNT * BIN_CAPACITY + 1);

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DRY    = 3'd1;
    localparam logic [2:0] REQ_OVERWR = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_FETCH  = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_CONFLICT = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [2:0]              req_type;
        logic [11:0]             start_bin;
        logic [ELEMENT_BITS-1:0] item_value;
        logic [ELEMENT_BITS-1:0] label_value;
        logic                    run_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]              status;
        logic [4:0]              peak_size;
        logic [ELEMENT_BITS-1:0] label_out;
        logic                    all_empty;
        logic                    result_last;
    } out_item_t;
endpackage

// ----- rtl/core/brt_if.sv -----
// Valid/ready channel interface carrying one payload struct.
// Depends on brt_pkg.
interface brt_in_if import brt_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface brt_out_if import brt_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/brt_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module brt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/core/bin_run_table_engine.sv -----
// Channel   Dir  Payload
// in_ch     in   req_type start_bin item_value label_value run_last
// out_ch    out  status peak_size label_out all_empty result_last
// cfg       in   labeled_mode (wr_en / wr_data)
// Non-last transactions are only stored. On the last one: decode, then a check pass
// per bin (count read, serial probe of the bin's slots), then a commit pass per bin:
// insert/dry-run read the count only, overwrite/fetch also probe, remove also probes
// and reads the bin's last slot; fetch adds one emit per bin. Clear sweeps BIN_COUNT
// count entries. After reset the count store is swept to zero, no input taken. A
// result waits in the output register; the next emit stalls on it.
// Depends on brt_pkg, brt_if, brt_ram.
module bin_run_table_engine import brt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic wr_data,
    brt_in_if.sink    in_ch,
    brt_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_INIT, S_COLLECT, S_DECIDE, S_CNT_RD, S_CNT_WT, S_PROBE, S_PROBE_WT,
        S_NEXT, S_COMMIT, S_LAST_RD, S_LAST_WT, S_CLEAR, S_EMIT, S_WAIT
    } state_t;

    state_t state_reg;
    logic   labeled_reg;
    logic [ELEMENT_BITS-1:0] run_item_reg [MAX_RUN];
    logic [ELEMENT_BITS-1:0] run_lab_reg [MAX_RUN];
    logic [RLEN_W-1:0] run_len_reg, len_reg;
    logic [BIN_W-1:0]  run_start_reg;
    logic [2:0]        req_reg, st_reg;
    logic [TOT_W-1:0]  tot_reg;
    logic [RUN_W-1:0]  idx_reg;
    logic              pass_reg; // 0 check, 1 commit
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              found_reg;
    logic              full_reg;
    logic [SLOT_W-1:0] hit_reg;
    logic [4:0]        mbs_reg;
    logic [BIN_W:0]    sweep_reg;
    logic [ELEMENT_BITS-1:0] last_item_reg, last_lab_reg;
    out_item_t         out_reg;
    logic              ovalid_reg;

    // count RAM
    logic             c_we;
    logic [BIN_W-1:0] c_addr;
    logic [CNT_W-1:0] c_wd, c_rd;
    // slot RAMs
    logic              s_we;
    logic [ADDR_W-1:0] s_addr;
    logic [ELEMENT_BITS-1:0] i_wd, i_rd, l_wd, l_rd;
    logic              l_we;

    brt_ram #(.WIDTH(CNT_W), .DEPTH(BIN_COUNT)) u_cnt (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
    brt_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(BIN_COUNT*BIN_CAPACITY)) u_items (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(i_wd), .rdata(i_rd));
    brt_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(BIN_COUNT*BIN_CAPACITY)) u_labels (
        .clk(clk), .we(l_we), .addr(s_addr), .wdata(l_wd), .rdata(l_rd));

    logic [BIN_W-1:0] bin_cur;
    logic [ELEMENT_BITS-1:0] cur_item, cur_lab;
    logic [BIN_W:0] end_bin;
    assign bin_cur  = run_start_reg + BIN_W'(idx_reg);
    assign cur_item = run_item_reg[idx_reg];
    assign cur_lab  = run_lab_reg[idx_reg];
    assign end_bin  = {1'b0, run_start_reg} + (BIN_W+1)'(len_reg);

    logic ins_req;
    assign ins_req = (req_reg == REQ_INSERT) || (req_reg == REQ_DRY);

    always_comb
    begin
        c_we = 1'b0; c_addr = bin_cur; c_wd = cnt_reg;
        s_we = 1'b0; l_we = 1'b0;
        s_addr = {bin_cur, slot_reg};
        i_wd = cur_item; l_wd = labeled_reg ? cur_lab : '0;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                c_we = 1'b1; c_addr = sweep_reg[BIN_W-1:0]; c_wd = '0;
            end
            S_COMMIT:
            begin
                case (req_reg)
                    REQ_INSERT:
                    begin
                        c_we = 1'b1; c_wd = cnt_reg + 1'b1;
                        s_we = 1'b1; l_we = 1'b1;
                        s_addr = {bin_cur, cnt_reg[SLOT_W-1:0]};
                    end
                    REQ_OVERWR:
                    begin
                        l_we = labeled_reg; l_wd = cur_lab;
                        s_addr = {bin_cur, hit_reg};
                    end
                    REQ_REMOVE:
                    begin
                        c_we = 1'b1; c_wd = cnt_reg - 1'b1;
                        s_we = 1'b1; l_we = 1'b1;
                        s_addr = {bin_cur, hit_reg};
                        i_wd = last_item_reg; l_wd = last_lab_reg;
                    end
                    default: s_addr = {bin_cur, hit_reg};
                endcase
            end
            S_LAST_RD:
                s_addr = {bin_cur, SLOT_W'(cnt_reg - 1'b1)};
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            labeled_reg <= 1'b0;
            run_len_reg <= '0;
            run_start_reg <= '0;
            tot_reg     <= '0;
            sweep_reg   <= '0;
            ovalid_reg  <= 1'b0;
            idx_reg <= '0; pass_reg <= 1'b0; slot_reg <= '0; cnt_reg <= '0;
            found_reg <= 1'b0; hit_reg <= '0; mbs_reg <= '0; st_reg <= ST_OK;
            req_reg <= REQ_INSERT; len_reg <= '0; full_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                labeled_reg <= wr_data;
            if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (BIN_W+1)'(BIN_COUNT - 1))
                        state_reg <= S_COLLECT;
                end
                S_COLLECT:
                begin
                    if (in_ch.valid)
                    begin
                        if (run_len_reg == '0)
                            run_start_reg <= in_ch.data.start_bin[BIN_W-1:0];
                        if (run_len_reg < RLEN_W'(MAX_RUN))
                        begin
                            run_item_reg[run_len_reg[RUN_W-1:0]] <= in_ch.data.item_value;
                            run_lab_reg[run_len_reg[RUN_W-1:0]] <= in_ch.data.label_value;
                            run_len_reg <= run_len_reg + 1'b1;
                        end
                        else
                            run_len_reg <= RLEN_W'(MAX_RUN + 1);
                        if (in_ch.data.run_last)
                        begin
                            len_reg <= (run_len_reg < RLEN_W'(MAX_RUN))
                                ? run_len_reg + 1'b1 : RLEN_W'(MAX_RUN + 1);
                            run_len_reg <= '0;
                            req_reg <= in_ch.data.req_type;
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    idx_reg <= '0; pass_reg <= 1'b0; mbs_reg <= '0;
                    st_reg <= ST_OK; full_reg <= 1'b0;
                    if (req_reg == REQ_CLEAR)
                    begin
                        sweep_reg <= '0; state_reg <= S_CLEAR;
                    end
                    else if (req_reg > REQ_CLEAR)
                    begin
                        st_reg <= ST_RANGE; state_reg <= S_EMIT;
                    end
                    else if (len_reg > RLEN_W'(MAX_RUN))
                    begin
                        st_reg <= ST_TOO_LONG; state_reg <= S_EMIT;
                    end
                    else if (end_bin > (BIN_W+1)'(BIN_COUNT))
                    begin
                        st_reg <= ST_RANGE; state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_CNT_RD;
                end
                S_CNT_RD: state_reg <= S_CNT_WT;
                S_CNT_WT:
                begin
                    cnt_reg <= c_rd; slot_reg <= '0; found_reg <= 1'b0;
                    // insert and dry-run commit need only the count
                    state_reg <= (c_rd == '0 || (pass_reg && ins_req)) ? S_NEXT : S_PROBE;
                end
                S_PROBE: state_reg <= S_PROBE_WT;
                S_PROBE_WT:
                begin
                    if (i_rd == cur_item && !found_reg)
                    begin
                        found_reg <= 1'b1; hit_reg <= slot_reg;
                    end
                    if ((CNT_W'(slot_reg) + 1'b1 < cnt_reg) && !(i_rd == cur_item))
                    begin
                        slot_reg <= slot_reg + 1'b1; state_reg <= S_PROBE;
                    end
                    else
                        state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (!pass_reg)
                    begin
                        if (ins_req && found_reg)
                        begin
                            st_reg <= ST_CONFLICT; state_reg <= S_EMIT;
                        end
                        else if (!ins_req && !found_reg)
                        begin
                            st_reg <= ST_CONFLICT; state_reg <= S_EMIT;
                        end
                        else if (RLEN_W'(idx_reg) + 1'b1 == len_reg)
                        begin
                            idx_reg <= '0; pass_reg <= 1'b1;
                            // a full bin is reported only once no bin conflicts
                            if (ins_req && (full_reg || cnt_reg >= CNT_W'(BIN_CAPACITY)))
                            begin
                                st_reg <= ST_FULL; state_reg <= S_EMIT;
                            end
                            else
                                state_reg <= S_CNT_RD;
                        end
                        else
                        begin
                            if (ins_req && cnt_reg >= CNT_W'(BIN_CAPACITY))
                                full_reg <= 1'b1;
                            idx_reg <= idx_reg + 1'b1; state_reg <= S_CNT_RD;
                        end
                    end
                    else if (req_reg == REQ_REMOVE)
                        state_reg <= S_LAST_RD;
                    else
                        state_reg <= S_COMMIT;
                end
                S_LAST_RD: state_reg <= S_LAST_WT;
                S_LAST_WT:
                begin
                    last_item_reg <= i_rd; last_lab_reg <= l_rd;
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    // full check already done in the check pass, before any write
                    if (ins_req && (5'(cnt_reg) + 5'd1 > mbs_reg))
                        mbs_reg <= 5'(cnt_reg) + 5'd1;
                    if (req_reg == REQ_INSERT)
                        tot_reg <= tot_reg + 1'b1;
                    if (req_reg == REQ_REMOVE)
                        tot_reg <= tot_reg - 1'b1;
                    if (req_reg == REQ_FETCH)
                        state_reg <= S_EMIT;
                    else if (RLEN_W'(idx_reg) + 1'b1 == len_reg)
                        state_reg <= S_EMIT;
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1; state_reg <= S_CNT_RD;
                    end
                end
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (BIN_W+1)'(BIN_COUNT - 1))
                    begin
                        tot_reg <= '0; state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        out_reg.status <= st_reg;
                        out_reg.peak_size <= (st_reg == ST_OK && ins_req) ? mbs_reg : '0;
                        out_reg.label_out <= '0;
                        out_reg.all_empty <= (tot_reg == '0);
                        out_reg.result_last <= 1'b1;
                        state_reg <= S_COLLECT;
                        if (req_reg == REQ_FETCH && st_reg == ST_OK && pass_reg)
                        begin
                            out_reg.label_out <= labeled_reg ? l_rd : '0;
                            out_reg.result_last <= (RLEN_W'(idx_reg) + 1'b1 == len_reg);
                            if (RLEN_W'(idx_reg) + 1'b1 != len_reg)
                            begin
                                idx_reg <= idx_reg + 1'b1; state_reg <= S_CNT_RD;
                            end
                        end
                    end
                end
                default: state_reg <= S_COLLECT;
            endcase
        end
    end

    // label RAM read during S_COMMIT for fetch returns data in S_EMIT
    assign in_ch.ready  = (state_reg == S_COLLECT);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = out_reg;
endmodule
